// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk and off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define BLM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define BLM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// shared widths, register indexes, types and states of the battery monitor
// ----------------------------------------------------------------------------
package blm_pkg;

  // group size and field widths
  localparam int SAMPLES   = 8;
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 19;
  localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int MV_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int PCT_W     = 7;
  localparam int CONF_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // scaling and divider sizing
  localparam int PROD_W      = SUM_W + GAIN_W;
  localparam int NUM_W       = PROD_W + 1;
  localparam int MV_DEN      = SAMPLES * 16384;
  localparam int SPAN2_W     = MV_W + 1;
  localparam int PCT_NUM_W   = MV_W + 8;
  localparam int DVS_W       = SPAN2_W;
  localparam int DIV_CNT_W   = $clog2(PCT_NUM_W + 1);

  localparam logic [MV_W-1:0]   MV_MAX      = '1;
  localparam logic [PCT_W-1:0]  PCT_FULL    = PCT_W'(100);
  localparam logic [PCT_NUM_W-1:0] PCT_SCALE = PCT_NUM_W'(200);
  localparam logic [CONF_W-1:0] CONF_MAX    = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_MV      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_HYST_MV = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_CONFIRM = CFG_IDX_W'(5);

  // configuration as seen by the back end
  typedef struct packed {
    logic [GAIN_W-1:0] cal_gain;
    logic [MV_W-1:0]   empty_mv;
    logic [MV_W-1:0]   full_mv;
    logic [MV_W-1:0]   charge_mv;
    logic [MV_W-1:0]   charge_hyst_mv;
    logic [CONF_W-1:0] charge_confirm;
  } cfg_t;

  // front end to queue
  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } q_wr_t;

  // back end to divider
  typedef struct packed {
    logic                 start;
    logic [PCT_NUM_W-1:0] dividend;
    logic [DVS_W-1:0]     divisor;
  } div_req_t;

  // divider to back end
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [PCT_NUM_W-1:0] quotient;
  } div_rsp_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_CHARGE,
    BK_PCT_DIV,
    BK_PCT_WAIT,
    BK_OUT
  } back_state_t;

endpackage

// ===== hdl/blm_front.sv =====
// ----------------------------------------------------------------------------
// blm_front
// accepts samples, sums each group and pushes the group sum to the queue
// ----------------------------------------------------------------------------
module blm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [blm_pkg::SAMPLE_W-1:0]  sample_mv,
  input  logic                          q_full,
  output blm_pkg::q_wr_t                q_wr
);

  logic [blm_pkg::SUM_W-1:0] sample_sum;
  logic [blm_pkg::IDX_W-1:0] sample_index;
  logic [blm_pkg::SUM_W-1:0] sum_next;
  logic                      last;
  logic                      take;

  // the last word of a group needs room in the queue
  assign last         = (sample_index == blm_pkg::IDX_W'(blm_pkg::SAMPLES - 1));
  assign sample_stall = last && q_full;
  assign take         = sample_valid && !sample_stall;
  assign sum_next     = sample_sum + blm_pkg::SUM_W'(sample_mv);

  assign q_wr.push = take && last;
  assign q_wr.sum  = sum_next;

  // running sum and position in the group
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_index <= '0;
    end else if (take) begin
      if (last) begin
        sample_sum   <= '0;
        sample_index <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_index <= sample_index + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/blm_queue.sv =====
// ----------------------------------------------------------------------------
// blm_queue
// two-entry queue of group sums between front and back end
// ----------------------------------------------------------------------------
module blm_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  blm_pkg::q_wr_t             q_wr,
  output logic                       q_full,
  output logic                       q_valid,
  output logic [blm_pkg::SUM_W-1:0]  q_data,
  input  logic                       q_pop
);

  logic [blm_pkg::SUM_W-1:0] entry [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      entry[wr_ptr] <= q_wr.sum;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (q_wr.push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !q_wr.push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/blm_div.sv =====
// ----------------------------------------------------------------------------
// blm_div
// restoring divider, one quotient bit per cycle, for the percent division
// ----------------------------------------------------------------------------
module blm_div (
  input  logic                clk,
  input  logic                rst,
  input  blm_pkg::div_req_t   req,
  output blm_pkg::div_rsp_t   rsp
);

  logic [blm_pkg::PCT_NUM_W-1:0] quo;
  logic [blm_pkg::DVS_W-1:0]     rem;
  logic [blm_pkg::DVS_W-1:0]     dvs;
  logic [blm_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [blm_pkg::DVS_W:0]       shifted;
  logic [blm_pkg::DVS_W:0]       diff;
  logic                          ge;

  // one trial subtraction
  assign shifted = {rem, quo[blm_pkg::PCT_NUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[blm_pkg::PCT_NUM_W-2:0], ge};
      rem <= ge ? diff[blm_pkg::DVS_W-1:0] : shifted[blm_pkg::DVS_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= blm_pkg::DIV_CNT_W'(blm_pkg::PCT_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == blm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/blm_back.sv =====
// ----------------------------------------------------------------------------
// blm_back
// scales a group sum to millivolts, updates charge detection, finds percent
// ----------------------------------------------------------------------------
module blm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  blm_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  logic [blm_pkg::SUM_W-1:0]  q_data,
  output logic                       q_pop,
  output blm_pkg::div_req_t          div_req,
  input  blm_pkg::div_rsp_t          div_rsp,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [blm_pkg::MV_W-1:0]   battery_mv,
  output logic [blm_pkg::PCT_W-1:0]  percent,
  output logic                       charging
);

  blm_pkg::back_state_t state, state_next;

  logic [blm_pkg::SUM_W-1:0]     sum_r;
  logic [blm_pkg::PROD_W-1:0]    prod;
  logic [blm_pkg::NUM_W-1:0]     mv_quo;
  logic [blm_pkg::MV_W-1:0]      mv;
  logic [blm_pkg::PCT_W-1:0]     pct;
  logic [blm_pkg::CONF_W-1:0]    confirm_count;
  logic                          charging_flag;
  logic [blm_pkg::CONF_W-1:0]    count_inc;
  logic [blm_pkg::MV_W:0]        clear_level;
  logic [blm_pkg::MV_W-1:0]      span;
  logic [blm_pkg::MV_W-1:0]      above_empty;
  logic [blm_pkg::PCT_NUM_W-1:0] pct_num;
  logic                          at_empty;
  logic                          at_full;

  // doubled product over the group scale, a power of two, so a plain shift
  assign mv_quo = {prod, 1'b0} / blm_pkg::NUM_W'(blm_pkg::MV_DEN);

  // percent numerator and divisor
  assign span        = cfg.full_mv - cfg.empty_mv;
  assign above_empty = mv - cfg.empty_mv;
  assign pct_num     = blm_pkg::PCT_NUM_W'(above_empty) * blm_pkg::PCT_SCALE
                     + blm_pkg::PCT_NUM_W'(span);
  assign at_empty    = (mv <= cfg.empty_mv);
  assign at_full     = (mv >= cfg.full_mv);

  // charge confirmation terms
  assign count_inc   = (confirm_count == blm_pkg::CONF_MAX) ? confirm_count
                                                            : confirm_count + 1'b1;
  assign clear_level = {1'b0, mv} + {1'b0, cfg.charge_hyst_mv};

  assign battery_mv = mv;
  assign percent    = pct;
  assign charging   = charging_flag;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next       = state;
    q_pop            = 1'b0;
    result_valid     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = pct_num;
    div_req.divisor  = blm_pkg::DVS_W'({span, 1'b0});
    unique case (state)
      blm_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = blm_pkg::BK_MUL;
        end
      end
      blm_pkg::BK_MUL: begin
        state_next = blm_pkg::BK_SCALE;
      end
      blm_pkg::BK_SCALE: begin
        state_next = blm_pkg::BK_CHARGE;
      end
      blm_pkg::BK_CHARGE: begin
        if (at_empty || at_full) begin
          state_next = blm_pkg::BK_OUT;
        end else begin
          state_next = blm_pkg::BK_PCT_DIV;
        end
      end
      blm_pkg::BK_PCT_DIV: begin
        div_req.start = 1'b1;
        state_next    = blm_pkg::BK_PCT_WAIT;
      end
      blm_pkg::BK_PCT_WAIT: begin
        if (div_rsp.done) begin
          state_next = blm_pkg::BK_OUT;
        end
      end
      blm_pkg::BK_OUT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          state_next = blm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = blm_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_r <= q_data;
    end
    if (state == blm_pkg::BK_MUL) begin
      prod <= blm_pkg::PROD_W'(sum_r) * blm_pkg::PROD_W'(cfg.cal_gain);
    end
    if (state == blm_pkg::BK_SCALE) begin
      mv <= (|mv_quo[blm_pkg::NUM_W-1:blm_pkg::MV_W])
            ? blm_pkg::MV_MAX : mv_quo[blm_pkg::MV_W-1:0];
    end
    if (state == blm_pkg::BK_CHARGE) begin
      if (at_empty) begin
        pct <= '0;
      end else if (at_full) begin
        pct <= blm_pkg::PCT_FULL;
      end
    end
    if (state == blm_pkg::BK_PCT_WAIT && div_rsp.done) begin
      pct <= div_rsp.quotient[blm_pkg::PCT_W-1:0];
    end
  end

  // charge confirmation counter and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_count <= '0;
      charging_flag <= 1'b0;
    end else if (state == blm_pkg::BK_CHARGE) begin
      if (mv >= cfg.charge_mv) begin
        confirm_count <= count_inc;
        if (count_inc >= cfg.charge_confirm) begin
          charging_flag <= 1'b1;
        end
      end else if (clear_level < {1'b0, cfg.charge_mv}) begin
        confirm_count <= '0;
        charging_flag <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/battery_level_monitor_core.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor_core
// averages ADC samples into battery millivolts, percent and a charging flag
//
//   channel   direction  handshake                  word
//   sample    in         sample_valid/sample_stall  sample_mv
//   result    out        result_valid/result_stall  battery_mv, percent, charging
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// samples are taken one per cycle while sample_stall is low; a group of SAMPLES
// yields one result; the back end scales each group sum, checks for charging,
// then runs the one-bit-per-cycle percent divider unless at or past a span end
// a two-entry queue of group sums lets the front keep taking samples while
// the back end works or a result waits; sample_stall rises only on the last
// word of a group with the queue full
// synchronous reset clears sums, counters, flag and config to defaults
// ----------------------------------------------------------------------------
module battery_level_monitor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [blm_pkg::SAMPLE_W-1:0]   sample_mv,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [blm_pkg::MV_W-1:0]       battery_mv,
  output logic [blm_pkg::PCT_W-1:0]      percent,
  output logic                           charging,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blm_pkg::CFG_DAT_W-1:0]  cfg_data
);

  blm_pkg::cfg_t             cfg;
  blm_pkg::q_wr_t            q_wr;
  blm_pkg::div_req_t         div_req;
  blm_pkg::div_rsp_t         div_rsp;
  logic                      q_full;
  logic                      q_valid;
  logic [blm_pkg::SUM_W-1:0] q_data;
  logic                      q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_gain       <= blm_pkg::GAIN_W'(16384);
      cfg.empty_mv       <= blm_pkg::MV_W'(3300);
      cfg.full_mv        <= blm_pkg::MV_W'(4200);
      cfg.charge_mv      <= blm_pkg::MV_W'(4300);
      cfg.charge_hyst_mv <= blm_pkg::MV_W'(100);
      cfg.charge_confirm <= blm_pkg::CONF_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blm_pkg::REG_CAL_GAIN:       cfg.cal_gain       <= cfg_data;
        blm_pkg::REG_EMPTY_MV:       cfg.empty_mv       <= cfg_data;
        blm_pkg::REG_FULL_MV:        cfg.full_mv        <= cfg_data;
        blm_pkg::REG_CHARGE_MV:      cfg.charge_mv      <= cfg_data;
        blm_pkg::REG_CHARGE_HYST_MV: cfg.charge_hyst_mv <= cfg_data;
        blm_pkg::REG_CHARGE_CONFIRM: cfg.charge_confirm <= cfg_data[blm_pkg::CONF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample accumulation
  blm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_mv    (sample_mv),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  // group sum queue
  blm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // percent divider
  blm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // scaling, charge detection and percent
  blm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .battery_mv   (battery_mv),
    .percent      (percent),
    .charging     (charging)
  );

`include "assert_macros.svh"

  // queue never takes a sum while full
  `BLM_ASSERT_ALWAYS(a_queue_no_overflow, !(q_wr.push && q_full), "queue overflow")
  // divider is started only when free
  `BLM_ASSERT_ALWAYS(a_div_start_free, !(div_req.start && div_rsp.busy), "divider restarted")
  // a shown percent never exceeds one hundred
  `BLM_ASSERT_IMPLY(a_percent_range, result_valid, percent <= blm_pkg::PCT_FULL, "percent above 100")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for battery_level_monitor_core: streams ADC sample
// words in groups, predicts each battery reading (millivolts, percent and
// charging flag) from its own copy of the registers and state, and compares
// every reading the block emits, under random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;
  import blm_pkg::*;

  localparam int          DIRECTED_ITEMS = 3 * SAMPLES;
  localparam int          RANDOM_ITEMS   = 450;
  localparam int          DRAIN_CYCLES   = 2 * NUM_W + 40;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int          SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int          MV_TOP         = (1 << MV_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  // battery level classes used to shape sample groups
  typedef enum int {
    LVL_LOW, LVL_SPAN, LVL_FULL, LVL_CHARGE, LVL_BAND, LVL_DROP, LVL_NOISE
  } level_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             chg;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_stall;
  logic [SAMPLE_W-1:0]  sample_mv;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [MV_W-1:0]      battery_mv;
  logic [PCT_W-1:0]     percent;
  logic                 charging;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // predicted register file
  logic [GAIN_W-1:0]    gain_q14;
  logic [MV_W-1:0]      empty_lvl;
  logic [MV_W-1:0]      full_lvl;
  logic [MV_W-1:0]      charge_lvl;
  logic [MV_W-1:0]      hyst_lvl;
  logic [CONF_W-1:0]    confirm_need;

  // predicted block state
  logic [SUM_W-1:0]     acc_sum;
  int unsigned          acc_count;
  logic [CONF_W-1:0]    high_count;
  logic                 chg_flag;

  reading_t             pending_readings[$];
  reading_t             want;
  bit                   idle_on;
  bit                   settled;
  int unsigned          stall_left;
  int unsigned          cycle_count;
  int unsigned          samples_sent;
  int unsigned          readings_checked;
  int unsigned          reg_writes;
  int unsigned          charging_seen;
  int unsigned          mismatches;

  battery_level_monitor_core DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_mv    (sample_mv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .battery_mv   (battery_mv),
    .percent      (percent),
    .charging     (charging),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[battery_level_monitor_core] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // averaged sum times two times gain, truncated, saturated
  function automatic logic [MV_W-1:0] scale_to_mv(logic [SUM_W-1:0] sum);
    longint unsigned prod;
    prod = 64'(sum) * 64'd2 * 64'(gain_q14);
    prod = prod / 64'(SAMPLES * 16384);
    return (prod > 64'(MV_MAX)) ? MV_MAX : MV_W'(prod);
  endfunction

  // linear fraction between empty and full, rounded half up
  function automatic logic [PCT_W-1:0] mv_to_percent(logic [MV_W-1:0] v);
    int unsigned span;
    int unsigned num;
    if (v <= empty_lvl) return '0;
    if (v >= full_lvl) return PCT_FULL;
    span = 32'(full_lvl) - 32'(empty_lvl);
    num = 200 * (int'(v) - int'(empty_lvl)) + span;
    return PCT_W'(num / (2 * span));
  endfunction

  // confirmation counter and charging flag with hysteresis
  task automatic update_charge_state(logic [MV_W-1:0] v);
    if (v >= charge_lvl) begin
      if (high_count != CONF_MAX) high_count++;
      if (high_count >= confirm_need) chg_flag = 1'b1;
    end else if (int'(v) + int'(hyst_lvl) < int'(charge_lvl)) begin
      high_count = '0;
      chg_flag = 1'b0;
    end
  endtask

  // add one accepted word; a full group yields one expected reading
  task automatic accumulate_sample(logic [SAMPLE_W-1:0] s);
    reading_t r;
    acc_sum = acc_sum + SUM_W'(s);
    acc_count++;
    if (acc_count == SAMPLES) begin
      r.mv = scale_to_mv(acc_sum);
      acc_sum = '0;
      acc_count = 0;
      update_charge_state(r.mv);
      r.pct = mv_to_percent(r.mv);
      r.chg = chg_flag;
      pending_readings.push_back(r);
    end
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_CAL_GAIN:       gain_q14 = data;
      REG_EMPTY_MV:       empty_lvl = data;
      REG_FULL_MV:        full_lvl = data;
      REG_CHARGE_MV:      charge_lvl = data;
      REG_CHARGE_HYST_MV: hyst_lvl = data;
      REG_CHARGE_CONFIRM: confirm_need = data[CONF_W-1:0];
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------------
  // result checking and result-side stall
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: mv=%0d pct=%0d chg=%0b",
                   battery_mv, percent, charging);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (charging === 1'b1) charging_seen++;
        if (battery_mv !== want.mv || percent !== want.pct || charging !== want.chg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading %0d: expected mv=%0d pct=%0d chg=%0b, got mv=%0d pct=%0d chg=%0b",
                     readings_checked, want.mv, want.pct, want.chg,
                     battery_mv, percent, charging);
        end
      end
      stall_left = idle_on ? $urandom_range(0, 12) : 0;
    end
    result_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // send one sample word, holding it until accepted
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_mv <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    accumulate_sample(s);
    samples_sent++;
    settled = 1'b0;
  endtask

  // write one register once the block has no reading in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    sample_valid <= 1'b0;
    if (!settled) begin
      while (pending_readings.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      settled = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // battery millivolts to aim for in a given class
  function automatic int pick_target(level_t lvl);
    int e;
    int f;
    int c;
    int h;
    e = int'(empty_lvl);
    f = int'(full_lvl);
    c = int'(charge_lvl);
    h = int'(hyst_lvl);
    case (lvl)
      LVL_LOW:    return $urandom_range(0, e);
      LVL_SPAN:   return $urandom_range(e, f);
      LVL_FULL:   return ((f > 20) ? f - 20 : 0) + $urandom_range(0, 40);
      LVL_CHARGE: return c + $urandom_range(0, 200);
      LVL_BAND:   return (c == 0) ? 0 : $urandom_range((c > h) ? c - h : 0, c - 1);
      LVL_DROP:   return (c > h) ? $urandom_range(0, c - h - 1) : 0;
      default:    return 0;
    endcase
  endfunction

  // divider-pin word that lands near the target under the current gain
  function automatic logic [SAMPLE_W-1:0] sample_for(int target);
    int s;
    if (gain_q14 == '0) return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    s = (target * 8192) / int'(gain_q14);
    s = s + int'($urandom_range(0, 2)) - 1;
    if (s < 0) s = 0;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    return SAMPLE_W'(s);
  endfunction

  // complete the current group at one level; some groups turn to noise
  task automatic send_level_group(level_t lvl);
    int target;
    int unsigned n;
    int unsigned broken_at;
    target = pick_target(lvl);
    broken_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SAMPLES - 1) : SAMPLES;
    n = SAMPLES - acc_count;
    for (int unsigned k = 0; k < n; k++) begin
      if (lvl == LVL_NOISE || k >= broken_at)
        send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      else
        send_sample(sample_for(target));
    end
  endtask

  // runs of groups at a random level, so counters get to build up
  task automatic run_levels(int unsigned groups);
    level_t lvl;
    int unsigned run;
    run = 0;
    lvl = LVL_NOISE;
    for (int unsigned g = 0; g < groups; g++) begin
      if (run == 0) begin
        lvl = level_t'($urandom_range(0, LVL_NOISE));
        run = $urandom_range(1, 4);
      end
      send_level_group(lvl);
      run--;
    end
  endtask

  // mostly plausible values, sometimes an extreme
  function automatic logic [CFG_DAT_W-1:0] draw_value(int lo, int hi, int top);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DAT_W'(top);
      default: return CFG_DAT_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // empty, full-scale and alternating-bit groups at reset settings
  task automatic test_field_extremes();
    idle_on = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < SAMPLES; k++) send_sample('0);
    for (int k = 0; k < SAMPLES; k++) send_sample(SAMPLE_W'(SAMPLE_MAX));
    for (int k = 0; k < SAMPLES; k++) send_sample(k[0] ? 12'hAAA : 12'h555);
  endtask

  // confirmation build-up, hysteresis band hold and clearing drop
  task automatic test_charge_confirm();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_CHARGE_MV, 16'd4000);
    write_reg(REG_CHARGE_HYST_MV, 16'd150);
    write_reg(REG_CHARGE_CONFIRM, 16'd2);
    repeat (3) send_level_group(LVL_CHARGE);
    repeat (2) send_level_group(LVL_BAND);
    send_level_group(LVL_CHARGE);
    send_level_group(LVL_DROP);
    repeat (2) send_level_group(LVL_CHARGE);
    send_level_group(LVL_BAND);
    send_level_group(LVL_DROP);
  endtask

  // zero confirm count; upper data bits of the 8-bit register are dropped
  task automatic test_zero_confirm();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_CHARGE_CONFIRM, 16'hFF00);
    send_level_group(LVL_DROP);
    send_level_group(LVL_CHARGE);
    send_level_group(LVL_BAND);
    send_level_group(LVL_DROP);
    send_level_group(LVL_CHARGE);
  endtask

  // full not above empty: no division, 0 or 100 only
  task automatic test_inverted_span();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_EMPTY_MV, 16'd4000);
    write_reg(REG_FULL_MV, 16'd3500);
    repeat (3) send_level_group(LVL_SPAN);
    send_level_group(LVL_LOW);
    send_level_group(LVL_FULL);
    write_reg(REG_FULL_MV, 16'd4000);
    // exactly on the shared level
    for (int k = 0; k < SAMPLES; k++) send_sample(12'd2000);
    repeat (2) send_level_group(LVL_SPAN);
    send_level_group(LVL_FULL);
  endtask

  // narrow span so that exact halves come up often
  task automatic test_half_up_rounding();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_EMPTY_MV, 16'd3000);
    write_reg(REG_FULL_MV, 16'd3200);
    repeat (6) send_level_group(LVL_SPAN);
    send_level_group(LVL_FULL);
  endtask

  // hysteresis above the charge level: the flag can never clear
  task automatic test_wide_hysteresis();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_CHARGE_MV, 16'd3000);
    write_reg(REG_CHARGE_HYST_MV, 16'd5000);
    write_reg(REG_CHARGE_CONFIRM, 16'd1);
    repeat (2) send_level_group(LVL_CHARGE);
    repeat (2) send_level_group(LVL_LOW);
    send_level_group(LVL_DROP);
    send_level_group(LVL_NOISE);
  endtask

  // zero and maximum gain, with thresholds at the ends of their range
  task automatic test_gain_extremes();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_CAL_GAIN, '0);
    repeat (2) send_level_group(LVL_NOISE);
    write_reg(REG_CAL_GAIN, 16'hFFFF);
    write_reg(REG_EMPTY_MV, '0);
    write_reg(REG_FULL_MV, 16'hFFFF);
    write_reg(REG_CHARGE_MV, '0);
    for (int k = 0; k < SAMPLES; k++) send_sample(SAMPLE_W'(SAMPLE_MAX));
    repeat (2) send_level_group(LVL_NOISE);
    send_level_group(LVL_SPAN);
    write_reg(REG_CHARGE_MV, 16'hFFFF);
    write_reg(REG_CHARGE_CONFIRM, 16'h00FF);
    repeat (2) send_level_group(LVL_SPAN);
  endtask

  // writes to indexes past the register file change nothing
  task automatic test_unknown_index();
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_CAL_GAIN, 16'd16384);
    write_reg(REG_EMPTY_MV, 16'd3300);
    write_reg(REG_FULL_MV, 16'd4200);
    write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom_range(0, MV_TOP)));
    write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom_range(0, MV_TOP)));
    run_levels(4);
  endtask

  // register writes with a partial group already summed
  task automatic test_mid_group_write();
    idle_on = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < 3; k++) send_sample(SAMPLE_W'($urandom_range(1500, 2200)));
    write_reg(REG_CAL_GAIN, CFG_DAT_W'($urandom_range(12000, 20000)));
    send_level_group(LVL_SPAN);
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_W'($urandom_range(1500, 2200)));
    write_reg(REG_EMPTY_MV, CFG_DAT_W'($urandom_range(2800, 3400)));
    send_level_group(LVL_SPAN);
  endtask

  // random settings of every register, each followed by level runs
  task automatic test_random_configs();
    logic [CFG_DAT_W-1:0] conf_word;
    while (samples_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_CAL_GAIN, draw_value(12000, 24000, MV_TOP));
      write_reg(REG_EMPTY_MV, draw_value(2500, 3600, MV_TOP));
      write_reg(REG_FULL_MV, draw_value(3700, 4500, MV_TOP));
      write_reg(REG_CHARGE_MV, draw_value(3500, 4600, MV_TOP));
      write_reg(REG_CHARGE_HYST_MV, draw_value(0, 300, MV_TOP));
      conf_word = draw_value(0, 6, CONF_MAX);
      conf_word[CFG_DAT_W-1:CONF_W] = (CFG_DAT_W - CONF_W)'($urandom_range(0, 255));
      write_reg(REG_CHARGE_CONFIRM, conf_word);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DAT_W'($urandom_range(0, MV_TOP)));
      run_levels(6);
    end
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample_mv <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CAL_GAIN;
    cfg_data <= '0;
    gain_q14 = GAIN_W'(16384);
    empty_lvl = MV_W'(3300);
    full_lvl = MV_W'(4200);
    charge_lvl = MV_W'(4300);
    hyst_lvl = MV_W'(100);
    confirm_need = CONF_W'(3);
    acc_sum = '0;
    acc_count = 0;
    high_count = '0;
    chg_flag = 1'b0;
    idle_on = 1'b0;
    settled = 1'b1;
    stall_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_charge_confirm();
    test_zero_confirm();
    test_inverted_span();
    test_half_up_rounding();
    test_wide_hysteresis();
    test_gain_extremes();
    test_unknown_index();
    test_mid_group_write();
    test_random_configs();

    // drain outstanding readings, then watch for strays
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sample words, %0d readings checked, %0d register writes",
             samples_sent, readings_checked, reg_writes);
    $display("charging reported on %0d readings, %0d mismatches", charging_seen, mismatches);
    if (mismatches == 0)
      $display("[battery_level_monitor_core] OK");
    else
      $display("[battery_level_monitor_core] ERROR");
    $finish;
  end

endmodule
